FILE: rtl/chkv_pkg.sv
// Package: shared constants, command and status codes, state type for the key-value store.
`default_nettype none
package chkv_pkg;
    localparam int BUCKETS_DEF     = 64;
    localparam int NODES_DEF       = 256;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int KEY_WIDTH       = 32;
    localparam int CMD_WIDTH       = 3;
    localparam int STATUS_WIDTH    = 2;
    localparam int OUT_WIDTH       = 32;

    localparam logic [CMD_WIDTH-1:0] CMD_GET    = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_PUT    = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_UPDATE = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [STATUS_WIDTH-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,      // sweep bucket heads to null
        S_IDLE,
        S_HASH,      // fold key, start remainder
        S_DIV,       // wait for bucket remainder
        S_HEAD,      // read bucket head
        S_HEADW,     // head data available
        S_NODE,      // node read issued, wait
        S_NODEW,     // compare key
        S_FREE,      // read free node link
        S_FREEW,
        S_RESP
    } state_t;
endpackage
`default_nettype wire

FILE: rtl/chained_hash_key_value_store.sv
// Top level: chained hash key-value store with a node pool and free list.
// Commands get, put, delete, update and clear each give one result transaction.
// One command is worked at a time. A get, put, delete or update passes the index
// start, the bucket remainder and the bucket head read, then a read and a compare
// for each chain node walked; a put takes a fresh node or reuses a freed one. After
// reset, and inside every clear, a sweep nulls every bucket head while no command
// is accepted.
`default_nettype none
module chained_hash_key_value_store #(
    parameter int BUCKETS     = chkv_pkg::BUCKETS_DEF,
    parameter int NODES       = chkv_pkg::NODES_DEF,
    parameter int VALUE_WIDTH = chkv_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [chkv_pkg::CMD_WIDTH-1:0]    cmd,
    input  wire logic signed [chkv_pkg::KEY_WIDTH-1:0] key,
    input  wire logic [chkv_pkg::KEY_WIDTH-1:0]    data_word,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [chkv_pkg::STATUS_WIDTH-1:0]      status,
    output logic [chkv_pkg::OUT_WIDTH-1:0]         value_out
);
    import chkv_pkg::*;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PW = $clog2(NODES + 1);
    localparam logic [PW-1:0] NIL = PW'(NODES);

    state_t state_reg, state_next;
    logic [CMD_WIDTH-1:0]   cmd_reg, cmd_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [VALUE_WIDTH-1:0] data_reg, data_next;
    logic [BW-1:0]          bkt_reg, bkt_next;
    logic [PW-1:0]          cur_reg, cur_next;
    logic [PW-1:0]          prev_reg, prev_next;
    logic [PW-1:0]          fresh_reg, fresh_next;
    logic [PW-1:0]          free_reg, free_next;
    logic [PW-1:0]          steps_reg, steps_next;
    logic [BW:0]            sweep_reg, sweep_next;
    logic [STATUS_WIDTH-1:0] st_reg, st_next;
    logic [OUT_WIDTH-1:0]   val_reg, val_next;

    logic                   idx_start, idx_done;
    logic [BW-1:0]          idx_bucket;
    logic                   h_we;
    logic [BW-1:0]          h_waddr, h_raddr;
    logic [PW-1:0]          h_wdata, h_rdata;
    logic                   n_we_key, n_we_val, n_we_link;
    logic [NW-1:0]          n_waddr, n_raddr;
    logic [PW-1:0]          n_wlink, n_rlink;
    logic [VALUE_WIDTH-1:0] n_rval;
    logic [KEY_WIDTH-1:0]   n_rkey;

    chkv_bucket_idx #(.BUCKETS(BUCKETS), .BW(BW)) u_idx (
        .clk(clk), .rst_n(rst_n), .start(idx_start), .key(key_reg),
        .done(idx_done), .bucket(idx_bucket)
    );

    chkv_head_mem #(.DEPTH(BUCKETS), .AW(BW), .DW(PW)) u_head (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    chkv_node_mem #(.DEPTH(NODES), .AW(NW), .VW(VALUE_WIDTH), .LW(PW)) u_node (
        .clk(clk), .we_key(n_we_key), .we_val(n_we_val), .we_link(n_we_link),
        .waddr(n_waddr), .wkey(key_reg), .wval(data_reg), .wlink(n_wlink),
        .raddr(n_raddr), .rkey(n_rkey), .rval(n_rval), .rlink(n_rlink)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESP);
    assign status    = st_reg;
    assign value_out = val_reg;

    // Command sequencer
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        data_next  = data_reg;
        bkt_next   = bkt_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        fresh_next = fresh_reg;
        free_next  = free_reg;
        steps_next = steps_reg;
        sweep_next = sweep_reg;
        st_next    = st_reg;
        val_next   = val_reg;
        idx_start  = 1'b0;
        h_we       = 1'b0;
        h_waddr    = bkt_reg;
        h_wdata    = NIL;
        h_raddr    = bkt_reg;
        n_we_key   = 1'b0;
        n_we_val   = 1'b0;
        n_we_link  = 1'b0;
        n_waddr    = NW'(cur_reg);
        n_wlink    = h_rdata;
        n_raddr    = NW'(cur_reg);
        case (state_reg)
            S_INIT:
            begin
                h_we       = 1'b1;
                h_waddr    = BW'(sweep_reg);
                h_wdata    = NIL;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == (BW+1)'(BUCKETS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    key_next   = key;
                    data_next  = VALUE_WIDTH'(data_word);
                    st_next    = ST_OK;
                    val_next   = '0;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                idx_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (idx_done)
                begin
                    bkt_next = idx_bucket;
                    case (cmd_reg)
                        CMD_GET, CMD_PUT, CMD_DELETE, CMD_UPDATE:
                            state_next = S_HEAD;
                        CMD_CLEAR:
                        begin
                            fresh_next = '0;
                            free_next  = NIL;
                            sweep_next = '0;
                            state_next = S_INIT;
                        end
                        default:
                            state_next = S_RESP;
                    endcase
                end
            end
            S_HEAD:
            begin
                // head read issued with h_raddr = bkt_reg
                state_next = S_HEADW;
            end
            S_HEADW:
            begin
                if (cmd_reg == CMD_PUT)
                begin
                    if (fresh_reg < NIL)
                    begin
                        cur_next   = fresh_reg;
                        fresh_next = fresh_reg + 1'b1;
                        prev_next  = h_rdata;
                        state_next = S_FREEW;
                    end
                    else if (free_reg < NIL)
                    begin
                        cur_next   = free_reg;
                        prev_next  = h_rdata;
                        state_next = S_FREE;
                    end
                    else
                    begin
                        st_next    = ST_FULL;
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    cur_next   = h_rdata;
                    prev_next  = NIL;
                    steps_next = '0;
                    state_next = S_NODE;
                end
            end
            S_FREE:
            begin
                // read link of the free node
                state_next = S_FREEW;
            end
            S_FREEW:
            begin
                // free_reg pops only when reused from the free list
                if (cur_reg == free_reg)
                    free_next = n_rlink;
                n_we_key  = 1'b1;
                n_we_val  = 1'b1;
                n_we_link = 1'b1;
                n_wlink   = prev_reg;
                h_we      = 1'b1;
                h_wdata   = cur_reg;
                state_next = S_RESP;
            end
            S_NODE:
            begin
                if (cur_reg >= NIL || steps_reg == NIL)
                begin
                    st_next    = ST_MISS;
                    state_next = S_RESP;
                end
                else
                    state_next = S_NODEW;
            end
            S_NODEW:
            begin
                if (n_rkey == key_reg)
                begin
                    state_next = S_RESP;
                    case (cmd_reg)
                        CMD_GET:
                            val_next = OUT_WIDTH'(n_rval);
                        CMD_UPDATE:
                            n_we_val = 1'b1;
                        CMD_DELETE:
                        begin
                            // unlink: predecessor or head takes our link
                            if (prev_reg < NIL)
                            begin
                                n_we_link = 1'b1;
                                n_waddr   = NW'(prev_reg);
                                n_wlink   = n_rlink;
                            end
                            else
                            begin
                                h_we    = 1'b1;
                                h_wdata = n_rlink;
                            end
                            cur_next   = cur_reg;
                            prev_next  = free_reg;
                            free_next  = cur_reg;
                            state_next = S_FREE;
                        end
                        default:
                            ;
                    endcase
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = n_rlink;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_NODE;
                end
            end
            S_RESP:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        // Delete finish: write freed node's link to old free head
        if (state_reg == S_FREE && cmd_reg == CMD_DELETE)
        begin
            n_we_link  = 1'b1;
            n_waddr    = NW'(cur_reg);
            n_wlink    = prev_reg;
            state_next = S_RESP;
        end
        // After clear sweep, still answer the command
        if (state_reg == S_INIT && sweep_reg == (BW+1)'(BUCKETS - 1)
            && cmd_reg == CMD_CLEAR)
            state_next = S_RESP;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cmd_reg   <= '0;
            fresh_reg <= '0;
            free_reg  <= NIL;
            sweep_reg <= '0;
            st_reg    <= ST_OK;
            val_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            fresh_reg <= fresh_next;
            free_reg  <= free_next;
            sweep_reg <= sweep_next;
            st_reg    <= st_next;
            val_reg   <= val_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        data_reg  <= data_next;
        bkt_reg   <= bkt_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        steps_reg <= steps_next;
    end
endmodule
`default_nettype wire

FILE: rtl/chkv_bucket_idx.sv
// Bucket index unit: folds the key and takes |rem| by BUCKETS with a reciprocal multiply and a multiply-back.
`default_nettype none
module chkv_bucket_idx #(
    parameter int BUCKETS = chkv_pkg::BUCKETS_DEF,
    parameter int BW      = 6
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [chkv_pkg::KEY_WIDTH-1:0] key,
    output logic                                done,
    output logic [BW-1:0]                       bucket
);
    import chkv_pkg::*;
    // Folded value spans -65536..65535, so its magnitude fits in 17 bits
    localparam int MW  = 17;
    localparam int LB  = $clog2(BUCKETS);
    localparam int SH  = MW + LB;
    localparam int RW  = MW + 1;
    localparam int PRW = MW + RW;
    localparam int DW  = $clog2(BUCKETS + 1);
    localparam longint RECIP = ((longint'(1) << SH) + longint'(BUCKETS) - 1)
                               / longint'(BUCKETS);
    localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
    localparam logic [MW+DW-1:0] DIVISOR = (MW + DW)'(BUCKETS);

    logic [MW-1:0]        mag_reg, mag_next;
    logic [MW-1:0]        quo_reg, quo_next;
    logic [MW-1:0]        rem_reg, rem_next;
    logic                 busy_reg, busy_next;
    logic [KEY_WIDTH-1:0] fold;
    logic [KEY_WIDTH-1:0] fneg;
    logic [MW-1:0]        fmag;
    logic [PRW-1:0]       prod;
    logic [MW+DW-1:0]     back;

    // Fold: low half xor sign-extended high half, then magnitude
    assign fold = {{16{key[31]}}, key[31:16] ^ key[15:0]};
    assign fneg = ~fold + 1'b1;
    assign fmag = fold[31] ? fneg[MW-1:0] : fold[MW-1:0];

    // Quotient by reciprocal, then remainder by multiply-back
    assign prod = PRW'(fmag) * PRW'(RECIP_V);
    assign back = (MW + DW)'(quo_reg) * DIVISOR;

    always_comb
    begin
        mag_next  = mag_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        busy_next = 1'b0;
        if (start)
        begin
            mag_next  = fmag;
            quo_next  = MW'(prod >> SH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
            rem_next = MW'((MW + DW)'(mag_reg) - back);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done   = !busy_reg && !start;
    assign bucket = BW'(rem_reg);
endmodule
`default_nettype wire

FILE: rtl/chkv_head_mem.sv
// Bucket head memory: one write port, one registered read port.
`default_nettype none
module chkv_head_mem #(
    parameter int DEPTH = chkv_pkg::BUCKETS_DEF,
    parameter int AW    = 6,
    parameter int DW    = 9
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [DW-1:0]      rdata
);
    logic [DW-1:0] mem [DEPTH];

    // Write and read, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/chkv_node_mem.sv
// Node pool memory: key, value and link per node, one write and one registered read port.
`default_nettype none
module chkv_node_mem #(
    parameter int DEPTH = chkv_pkg::NODES_DEF,
    parameter int AW    = 8,
    parameter int VW    = chkv_pkg::VALUE_WIDTH_DEF,
    parameter int LW    = 9
) (
    input  wire logic                           clk,
    input  wire logic                           we_key,
    input  wire logic                           we_val,
    input  wire logic                           we_link,
    input  wire logic [AW-1:0]                  waddr,
    input  wire logic [chkv_pkg::KEY_WIDTH-1:0] wkey,
    input  wire logic [VW-1:0]                  wval,
    input  wire logic [LW-1:0]                  wlink,
    input  wire logic [AW-1:0]                  raddr,
    output logic [chkv_pkg::KEY_WIDTH-1:0]      rkey,
    output logic [VW-1:0]                       rval,
    output logic [LW-1:0]                       rlink
);
    import chkv_pkg::*;
    logic [KEY_WIDTH-1:0] key_mem  [DEPTH];
    logic [VW-1:0]        val_mem  [DEPTH];
    logic [LW-1:0]        link_mem [DEPTH];

    // Write selected fields, read all registered
    always_ff @(posedge clk)
    begin
        if (we_key)
            key_mem[waddr] <= wkey;
        if (we_val)
            val_mem[waddr] <= wval;
        if (we_link)
            link_mem[waddr] <= wlink;
        rkey  <= key_mem[raddr];
        rval  <= val_mem[raddr];
        rlink <= link_mem[raddr];
    end
endmodule
`default_nettype wire

FILE: tb/sv/chained_hash_key_value_store_checker.sv
// Checker: watches both channels, predicts the key-value store results and compares them.
module chained_hash_key_value_store_checker
    import chkv_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic                     in_ready,
    input  wire logic [CMD_WIDTH-1:0]     cmd,
    input  wire logic signed [KEY_WIDTH-1:0] key,
    input  wire logic [KEY_WIDTH-1:0]     data_word,
    input  wire logic                     out_valid,
    input  wire logic                     out_ready,
    input  wire logic [STATUS_WIDTH-1:0]  status,
    input  wire logic [OUT_WIDTH-1:0]     value_out,
    output int                            fail_count,
    output int                            pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = BUCKETS_DEF;
    localparam int NN = NODES_DEF;
    localparam int NIL = NN;

    typedef struct packed {
        logic [STATUS_WIDTH-1:0] status;
        logic [OUT_WIDTH-1:0]    value;
    } answer_t;

    answer_t answer_queue[$];

    int unsigned heads[NB];
    logic [31:0] node_key[NN];
    logic [31:0] node_val[NN];
    int unsigned node_next[NN];
    int unsigned fresh_nodes;
    int unsigned free_list;

    // Fold the key halves and take the absolute truncated remainder.
    function automatic int unsigned bucket_index(logic [31:0] k);
        logic signed [31:0] folded;
        int signed rem;
        begin
            folded = {{16{k[31]}}, k[31:16]} ^ {16'h0000, k[15:0]};
            rem = folded % NB;
            bucket_index = (rem < 0) ? -rem : rem;
        end
    endfunction

    // Locate the newest match in a chain; prev is NIL when it is the head.
    function automatic int unsigned find_node(int unsigned b, logic [31:0] k,
                                              output int unsigned prev);
        int unsigned n;
        int unsigned p;
        begin
            n = heads[b];
            p = NIL;
            prev = NIL;
            find_node = NIL;
            for (int s = 0; s < NN && n < NIL; s++)
            begin
                if (node_key[n] == k)
                begin
                    prev = p;
                    find_node = n;
                    break;
                end
                p = n;
                n = node_next[n];
            end
        end
    endfunction

    // Apply one command to the shadow map and return its answer.
    function automatic answer_t apply_command(logic [2:0] c, logic [31:0] k, logic [31:0] d);
        answer_t a;
        int unsigned b;
        int unsigned n;
        int unsigned prev;
        begin
            a = '{ST_OK, '0};
            b = bucket_index(k);
            case (c)
                CMD_GET:
                begin
                    n = find_node(b, k, prev);
                    if (n < NIL) a.value = node_val[n];
                    else a.status = ST_MISS;
                end
                CMD_PUT:
                begin
                    n = NIL;
                    if (fresh_nodes < NIL)
                    begin
                        n = fresh_nodes;
                        fresh_nodes++;
                    end
                    else if (free_list < NIL)
                    begin
                        n = free_list;
                        free_list = node_next[n];
                    end
                    if (n < NIL)
                    begin
                        node_key[n] = k;
                        node_val[n] = d;
                        node_next[n] = heads[b];
                        heads[b] = n;
                    end
                    else a.status = ST_FULL;
                end
                CMD_DELETE:
                begin
                    n = find_node(b, k, prev);
                    if (n < NIL)
                    begin
                        if (prev < NIL) node_next[prev] = node_next[n];
                        else heads[b] = node_next[n];
                        node_next[n] = free_list;
                        free_list = n;
                    end
                    else a.status = ST_MISS;
                end
                CMD_UPDATE:
                begin
                    n = find_node(b, k, prev);
                    if (n < NIL) node_val[n] = d;
                    else a.status = ST_MISS;
                end
                CMD_CLEAR:
                begin
                    foreach (heads[i]) heads[i] = NIL;
                    fresh_nodes = 0;
                    free_list = NIL;
                end
                default: ;
            endcase
            apply_command = a;
        end
    endfunction

    assign pending_count = answer_queue.size();

    // Predict on accepted commands, compare accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        answer_t got;
        answer_t want;
        if (!rst_n)
        begin
            foreach (heads[i]) heads[i] = NIL;
            foreach (node_key[i])
            begin
                node_key[i] = '0;
                node_val[i] = '0;
                node_next[i] = 0;
            end
            fresh_nodes = 0;
            free_list = NIL;
            fail_count <= 0;
            answer_queue.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{status, value_out};
                if (answer_queue.size() == 0)
                begin
                    $error("unexpected result transaction status=%0d value_out=%h",
                           status, value_out);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = answer_queue.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status expected %0d actual %0d", want.status, got.status);
                        fail_count <= fail_count + 1;
                    end
                    else if (got.value !== want.value)
                    begin
                        $error("value_out expected %h actual %h", want.value, got.value);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                answer_queue.push_back(apply_command(cmd, key, data_word));
        end
    end
endmodule

FILE: tb/sv/chained_hash_key_value_store_tb.sv
// Testbench top: drives commands and result stalls, and reports the verdict.
module chained_hash_key_value_store_tb;
    import chkv_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [CMD_WIDTH-1:0]    cmd;
    logic signed [KEY_WIDTH-1:0] key;
    logic [KEY_WIDTH-1:0]    data_word;
    logic                    out_valid;
    logic                    out_ready;
    logic [STATUS_WIDTH-1:0] status;
    logic [OUT_WIDTH-1:0]    value_out;
    int                      fail_count;
    int                      pending_count;
    int                      send_idle_pct;
    int                      recv_stall_pct;
    logic [31:0]             key_pool[16];

    chained_hash_key_value_store i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .key(key), .data_word(data_word),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .value_out(value_out)
    );

    chained_hash_key_value_store_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .key(key), .data_word(data_word),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .value_out(value_out),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the result channel at random.
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Send one command transaction, idling before it at random.
    task automatic send_command(logic [2:0] c, logic [31:0] k, logic [31:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd       <= c;
        key       <= k;
        data_word <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Pick a key: mostly from a small pool with colliding buckets, sometimes wild.
    function automatic logic [31:0] pick_key();
        if ($urandom_range(9) == 0)
            pick_key = $urandom;
        else
            pick_key = key_pool[$urandom_range(15)];
    endfunction

    function automatic logic [2:0] pick_command();
        int r;
        r = $urandom_range(99);
        if (r < 30) pick_command = CMD_GET;
        else if (r < 62) pick_command = CMD_PUT;
        else if (r < 80) pick_command = CMD_DELETE;
        else if (r < 97) pick_command = CMD_UPDATE;
        else if (r < 98) pick_command = CMD_CLEAR;
        else pick_command = 3'($urandom_range(7, 5));
    endfunction

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_GET;
        key = '0;
        data_word = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        foreach (key_pool[i])
            key_pool[i] = (i < 8) ? 32'(i * 64 + 3) : $urandom;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every command, misses, duplicates, unused codes.
        send_command(CMD_GET, 32'h0000_0000, '0);
        send_command(CMD_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
        send_command(CMD_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
        send_command(CMD_PUT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_command(CMD_PUT, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
        send_command(CMD_GET, 32'hFFFF_FFFF, '0);
        send_command(CMD_GET, 32'h8000_0000, '0);
        send_command(CMD_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_GET, 32'h7FFF_FFFF, '0);
        send_command(CMD_DELETE, 32'hFFFF_FFFF, '0);
        send_command(CMD_GET, 32'hFFFF_FFFF, '0);
        send_command(CMD_DELETE, 32'h1234_5678, '0);
        send_command(CMD_UPDATE, 32'h1234_5678, 32'h1);
        send_command(3'd5, 32'h1, 32'h1);
        send_command(3'd6, '0, '0);
        send_command(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_command(CMD_CLEAR, '0, '0);
        send_command(CMD_GET, 32'h8000_0000, '0);

        // Fill the pool, overflow it, then delete and put pool keys while it is full.
        for (int i = 0; i < NODES_DEF + 3; i++)
            send_command(CMD_PUT, $urandom, $urandom);
        for (int i = 0; i < 4; i++)
            send_command(CMD_DELETE, key_pool[i], '0);
        for (int i = 0; i < 4; i++)
        begin
            send_command(CMD_PUT, key_pool[i], $urandom);
            send_command(CMD_DELETE, key_pool[i], '0);
        end
        send_command(CMD_CLEAR, '0, '0);

        // Random phases with different idle and stall mixes.
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            for (int i = 0; i < 250; i++)
                send_command(pick_command(), pick_key(), $urandom);
        end
        in_valid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        // Drain, then give the block time to settle.
        wait_cycles = 0;
        while (pending_count != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (400) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("chained_hash_key_value_store verification clean");
        else
            $display("chained_hash_key_value_store verification failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #60ms;
        $display("chained_hash_key_value_store verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/chkv_pkg.sv
rtl/chkv_bucket_idx.sv
rtl/chkv_head_mem.sv
rtl/chkv_node_mem.sv
rtl/chained_hash_key_value_store.sv
tb/sv/chained_hash_key_value_store_checker.sv
tb/sv/chained_hash_key_value_store_tb.sv
